// ===== sv/fpba_pkg.sv =====
// fpba_pkg: shared types and codes for the fit-policy block allocator.
// No dependencies; used by fpba_ctrl, fpba_dp, the top level and fpba_checker.
`default_nettype none

package fpba_pkg;

	// input command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	// placement policies (code 3 behaves as first fit)
	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	// configuration register indexes
	localparam logic CFG_FIT_MODE    = 1'b0;
	localparam logic CFG_BLOCK_COUNT = 1'b1;

	localparam logic [1:0] FIT_MODE_RST    = FIT_FIRST;
	localparam logic [4:0] BLOCK_COUNT_RST = 5'd16;

	// controller -> datapath commands
	typedef struct packed {
		logic load_we;  // write a load transfer into the table
		logic start;    // latch request, clear search state
		logic rd_en;    // issue one table read
		logic wb;       // write back chosen entry, load result register
	} dp_cmd_t;

endpackage

`default_nettype wire

// ===== sv/fpba_dp.sv =====
// fpba_dp: free-size table, scan compare and result registers.
// Depends on fpba_pkg; driven by fpba_ctrl.
`default_nettype none

module fpba_dp #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire fpba_pkg::dp_cmd_t             cmd,
	input  wire logic [$clog2(NUM_BLOCKS)-1:0] rd_addr,
	input  wire logic [1:0]                    fit_mode,
	input  wire logic [3:0]                    block_index,
	input  wire logic [15:0]                   size,
	output logic                               granted,
	output logic [3:0]                         chosen_block,
	output logic [15:0]                        remaining_after
);

	localparam int IdxW = $clog2(NUM_BLOCKS);

	logic [SIZE_BITS-1:0]  mem [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] valid_q;

	logic [SIZE_BITS-1:0] rd_data_s1;
	logic                 rd_live_s1;
	logic                 rd_vld_s1;
	logic [IdxW-1:0]      rd_idx_s1;

	logic [SIZE_BITS-1:0] req_q;
	logic [SIZE_BITS-1:0] best_q;
	logic [IdxW-1:0]      pick_q;
	logic                 found_q;

	logic [SIZE_BITS-1:0] in_size;
	logic [SIZE_BITS-1:0] cur;
	logic [SIZE_BITS-1:0] left;
	logic                 fits;
	logic                 take;
	logic                 load_ok;
	logic                 we;
	logic [IdxW-1:0]      wa;
	logic [SIZE_BITS-1:0] wd;

	assign in_size = SIZE_BITS'(size);
	assign load_ok = ({28'd0, block_index} < 32'(NUM_BLOCKS));
	assign cur     = rd_live_s1 ? rd_data_s1 : '0;
	assign fits    = (cur >= req_q);
	assign left    = best_q - req_q;

	always_comb begin
		case (fit_mode)
			fpba_pkg::FIT_BEST:  take = fits && (!found_q || cur < best_q);
			fpba_pkg::FIT_WORST: take = fits && (!found_q || cur > best_q);
			default:             take = fits && !found_q;
		endcase
	end

	// single write port: load or write-back
	always_comb begin
		if (cmd.wb) begin
			we = found_q;
			wa = pick_q;
			wd = left;
		end else begin
			we = cmd.load_we && load_ok;
			wa = IdxW'(block_index);
			wd = in_size;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_data_s1 <= mem[rd_addr];
		rd_idx_s1  <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_vld_s1  <= 1'b0;
			rd_live_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			if (we) begin
				valid_q[wa] <= 1'b1;
			end
			rd_vld_s1  <= cmd.rd_en;
			rd_live_s1 <= valid_q[rd_addr];
			if (cmd.start) begin
				found_q <= 1'b0;
			end else if (rd_vld_s1 && take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q <= in_size;
		end
		if (rd_vld_s1 && take) begin
			best_q <= cur;
			pick_q <= rd_idx_s1;
		end
		if (cmd.wb) begin
			granted         <= found_q;
			chosen_block    <= found_q ? 4'(pick_q) : 4'd0;
			remaining_after <= found_q ? 16'(left) : 16'd0;
		end
	end

endmodule

`default_nettype wire

// ===== sv/fpba_ctrl.sv =====
// fpba_ctrl: handshakes, configuration registers and scan sequencer.
// Depends on fpba_pkg; commands fpba_dp.
`default_nettype none

module fpba_ctrl #(
	parameter int NUM_BLOCKS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [4:0]                    cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          command,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output fpba_pkg::dp_cmd_t                  cmd,
	output logic [$clog2(NUM_BLOCKS)-1:0]      rd_addr,
	output logic [1:0]                         fit_mode
);

	localparam int IdxW = $clog2(NUM_BLOCKS);
	localparam int CntW = $clog2(NUM_BLOCKS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

	state_t          state_q;
	logic [CntW-1:0] idx_q;
	logic [4:0]      block_count_q;
	logic [CntW-1:0] lim;
	logic            in_xfer;
	logic            wb_go;

	assign lim = (32'(block_count_q) > 32'(NUM_BLOCKS)) ? CntW'(NUM_BLOCKS)
	                                                      : CntW'(block_count_q);

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign wb_go    = (state_q == ST_WRITE) && (!out_valid || out_ready);
	assign rd_addr  = idx_q[IdxW-1:0];

	always_comb begin
		cmd.load_we = in_xfer && (command == fpba_pkg::CMD_LOAD);
		cmd.start   = in_xfer && (command == fpba_pkg::CMD_ALLOC);
		cmd.rd_en   = (state_q == ST_SCAN) && (idx_q < lim);
		cmd.wb      = wb_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode      <= fpba_pkg::FIT_MODE_RST;
			block_count_q <= fpba_pkg::BLOCK_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fpba_pkg::CFG_FIT_MODE:    fit_mode      <= cfg_wdata[1:0];
				fpba_pkg::CFG_BLOCK_COUNT: block_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (wb_go) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (cmd.start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// last compare lands in the cycle idx_q reaches lim
					if (idx_q < lim) begin
						idx_q <= idx_q + CntW'(1);
					end else begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (wb_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/fit_policy_block_allocator.sv =====
// fit_policy_block_allocator: top level, controller plus datapath.
// Depends on fpba_pkg, fpba_ctrl and fpba_dp.
//
// Usage:
//  - Input channel (in_valid/in_ready): command, block_index, size.
//    A load transfer writes size into entry block_index (ignored if the
//    index is outside the table); no result.
//  - An allocate transfer scans entries 0 .. min(block_count, NUM_BLOCKS)-1
//    one per cycle through the table read port, then writes back the chosen
//    entry and registers the result; the next item is taken the cycle after
//    write-back.
//  - Output channel (out_valid/out_ready): granted, chosen_block,
//    remaining_after, held in an output register. Loads are still taken
//    while a result waits; an allocate that finishes its scan holds in
//    write-back until the output register is free.
//  - Config port: cfg_we, cfg_index (0 fit_mode, 1 block_count), cfg_wdata;
//    write only while idle.
//  - Reset (arst_n low): table reads as all zero, fit_mode first fit,
//    block_count 16, no result pending.
`default_nettype none

module fit_policy_block_allocator #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [4:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command,
	input  wire logic [3:0]  block_index,
	input  wire logic [15:0] size,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             granted,
	output logic [3:0]       chosen_block,
	output logic [15:0]      remaining_after
);

	fpba_pkg::dp_cmd_t                 cmd;
	logic [$clog2(NUM_BLOCKS)-1:0]     rd_addr;
	logic [1:0]                        fit_mode;

	// sequencer, handshakes and config registers
	fpba_ctrl #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.fit_mode  (fit_mode)
	);

	// table, running best pick, result register
	fpba_dp #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.SIZE_BITS (SIZE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.rd_addr         (rd_addr),
		.fit_mode        (fit_mode),
		.block_index     (block_index),
		.size            (size),
		.granted         (granted),
		.chosen_block    (chosen_block),
		.remaining_after (remaining_after)
	);

endmodule

`default_nettype wire

// ===== sv/fpba_checker.sv =====
// fpba_checker: port-level assertions for fit_policy_block_allocator.
// Depends on fpba_pkg; bound to the top level below.
`default_nettype none

module fpba_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        command,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        granted,
	input wire logic [3:0]  chosen_block,
	input wire logic [15:0] remaining_after
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(granted) && $stable(chosen_block) &&
			$stable(remaining_after))
		else $error("result changed while stalled");

	// refused request reports zero fields
	a_refuse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !granted |-> chosen_block == 4'd0 && remaining_after == 16'd0)
		else $error("refused result has nonzero fields");

	// allocate occupies the block
	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == fpba_pkg::CMD_ALLOC |=> !in_ready)
		else $error("input taken during allocate");

	// a new result only comes out of a busy phase
	a_rose_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without an allocate");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (.*);

`default_nettype wire
